// ===== rtl/dsm_pkg.sv =====
`timescale 1ns / 1ps
package dsm_pkg;

  typedef enum logic [2:0] {
    KIND_INIT     = 3'd0,
    KIND_SHUTDOWN = 3'd1,
    KIND_REGISTER = 3'd2,
    KIND_CANCEL   = 3'd3,
    KIND_COMPLETE = 3'd4,
    KIND_CHECK    = 3'd5,
    KIND_QUERY    = 3'd6,
    KIND_STAT     = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_INVALID  = 2'd1,
    STS_NOTFOUND = 2'd2,
    STS_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ENT_PENDING   = 2'd0,
    ENT_MET       = 2'd1,
    ENT_MISSED    = 2'd2,
    ENT_CANCELLED = 2'd3
  } entry_e;

  typedef enum logic [2:0] {
    SEL_REGISTERED = 3'd0,
    SEL_ACTIVE     = 3'd1,
    SEL_MET        = 3'd2,
    SEL_MISSED     = 3'd3,
    SEL_CANCELLED  = 3'd4,
    SEL_WORST      = 3'd5,
    SEL_BEST       = 3'd6,
    SEL_NONE       = 3'd7
  } sel_e;

  localparam int unsigned MaxReports = 16;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] time_ns;
    logic [63:0] owner_id;
    logic        miss_notify;
    logic [3:0]  handle_slot;
    logic [15:0] handle_generation;
    logic [2:0]  stat_select;
  } dsm_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         slot_index;
    logic [15:0]        generation;
    logic [1:0]         entry_state;
    logic [63:0]        miss_entity;
    logic [63:0]        overdue_ns;
    logic signed [63:0] stat_value;
    logic [4:0]         miss_count;
    logic               is_miss_report;
    logic               last;
  } dsm_rsp_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan;
    logic finish;
  } dsm_ctl_t;

  typedef struct packed {
    logic needs_scan;
    logic scan_end;
  } dsm_sts_t;

  function automatic logic [15:0] bump_gen(input logic [15:0] g);
    logic [15:0] n;
    n = g + 16'd1;
    return (n == 16'd0) ? 16'd1 : n;
  endfunction

  function automatic logic [63:0] late_margin(input logic [63:0] over);
    return over[63] ? 64'h8000_0000_0000_0000 : (64'd0 - over);
  endfunction

  function automatic logic [63:0] early_margin(input logic [63:0] raw);
    return raw[63] ? 64'h7FFF_FFFF_FFFF_FFFF : raw;
  endfunction

endpackage

// ===== rtl/dsm_ctrl.sv =====
`timescale 1ns / 1ps
module dsm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  dsm_pkg::dsm_sts_t sts_i,
  output dsm_pkg::dsm_ctl_t ctl_o,
  output logic              busy_o
);
  import dsm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctl_o.capture = 1'b1;
          state_d = sts_i.needs_scan ? ST_SCAN : ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl_o.exec = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        ctl_o.scan = 1'b1;
        if (sts_i.scan_end) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        ctl_o.finish = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ===== rtl/dsm_datapath.sv =====
`timescale 1ns / 1ps
module dsm_datapath #(
  parameter int unsigned SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dsm_pkg::dsm_req_t req_i,
  input  dsm_pkg::dsm_ctl_t ctl_i,
  output dsm_pkg::dsm_sts_t sts_o,
  output logic              rsp_valid_o,
  output dsm_pkg::dsm_rsp_t rsp_o
);
  import dsm_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned HW = (CW > 4) ? CW : 4;

  logic [63:0] target_q [SLOTS];
  logic [63:0] target_d [SLOTS];
  logic [63:0] entity_q [SLOTS];
  logic [63:0] entity_d [SLOTS];
  logic        notify_q [SLOTS];
  logic        notify_d [SLOTS];
  logic [15:0] gen_q [SLOTS];
  logic [15:0] gen_d [SLOTS];
  logic [1:0]  state_q [SLOTS];
  logic [1:0]  state_d [SLOTS];

  logic [CW-1:0] in_use_q, in_use_d;
  logic          running_q, running_d;
  logic [63:0]   reg_tot_q, reg_tot_d, act_tot_q, act_tot_d, met_tot_q, met_tot_d;
  logic [63:0]   miss_tot_q, miss_tot_d, canc_tot_q, canc_tot_d;
  logic [63:0]   worst_q, worst_d, best_q, best_d;

  dsm_req_t      req_q, req_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [IW-1:0] fidx_q, fidx_d;
  logic          found_q, found_d;
  logic [4:0]    rep_q, rep_d, misses_q, misses_d;
  logic          rsp_valid_d;
  dsm_rsp_t      rsp_d;

  logic [IW-1:0] rd_idx, hs_idx, alloc;
  logic          hs_ok, act, do_alloc;
  logic [1:0]    rd_state;
  logic [63:0]   rd_target, diff_fwd, diff_rev, margin;
  logic          note;

  assign hs_idx = IW'(req_q.handle_slot);
  assign hs_ok = (HW'(req_q.handle_slot) < HW'(in_use_q)) &&
                 (HW'(req_q.handle_slot) < HW'(SLOTS)) &&
                 (gen_q[hs_idx] == req_q.handle_generation);
  assign rd_idx = ctl_i.exec ? hs_idx : idx_q[IW-1:0];
  assign rd_state = state_q[rd_idx];
  assign rd_target = target_q[rd_idx];
  assign diff_fwd = rd_target - req_q.time_ns;
  assign diff_rev = req_q.time_ns - rd_target;
  assign act = (idx_q < in_use_q);

  always_comb begin
    sts_o.needs_scan = (req_i.kind == KIND_SHUTDOWN) ||
                       (((req_i.kind == KIND_REGISTER) || (req_i.kind == KIND_CHECK))
                        && running_q);
    sts_o.scan_end = !act || ((idx_q + CW'(1)) >= in_use_q) ||
                     ((req_q.kind == KIND_REGISTER) && (rd_state != ENT_PENDING));
  end

  always_comb begin
    target_d = target_q;
    entity_d = entity_q;
    notify_d = notify_q;
    gen_d = gen_q;
    state_d = state_q;
    in_use_d = in_use_q;
    running_d = running_q;
    reg_tot_d = reg_tot_q;
    act_tot_d = act_tot_q;
    met_tot_d = met_tot_q;
    miss_tot_d = miss_tot_q;
    canc_tot_d = canc_tot_q;
    worst_d = worst_q;
    best_d = best_q;
    req_d = req_q;
    idx_d = idx_q;
    fidx_d = fidx_q;
    found_d = found_q;
    rep_d = rep_q;
    misses_d = misses_q;
    rsp_valid_d = 1'b0;
    rsp_d = '0;
    rsp_d.last = 1'b1;
    margin = '0;
    note = 1'b0;
    do_alloc = 1'b0;
    alloc = fidx_q;

    if (ctl_i.capture) begin
      req_d = req_i;
      idx_d = '0;
      found_d = 1'b0;
      rep_d = '0;
      misses_d = '0;
    end

    if (ctl_i.exec) begin
      rsp_valid_d = 1'b1;
      case (req_q.kind)
        KIND_INIT: begin
          for (int i = 0; i < SLOTS; i++) begin
            gen_d[i] = bump_gen(gen_q[i]);
            state_d[i] = ENT_CANCELLED;
          end
          in_use_d = '0;
          reg_tot_d = '0;
          act_tot_d = '0;
          met_tot_d = '0;
          miss_tot_d = '0;
          canc_tot_d = '0;
          worst_d = '0;
          best_d = '0;
          running_d = 1'b1;
        end
        KIND_REGISTER: begin
          rsp_d.status = STS_INVALID;
        end
        KIND_CANCEL: begin
          if (!hs_ok) begin
            rsp_d.status = STS_NOTFOUND;
          end else if (rd_state == ENT_PENDING) begin
            state_d[hs_idx] = ENT_CANCELLED;
            canc_tot_d = canc_tot_q + 64'd1;
            if (act_tot_q != '0) act_tot_d = act_tot_q - 64'd1;
          end
        end
        KIND_COMPLETE: begin
          if (!hs_ok) begin
            rsp_d.status = STS_NOTFOUND;
          end else if (rd_state != ENT_PENDING) begin
            rsp_d.status = STS_INVALID;
          end else begin
            note = 1'b1;
            if (rd_target >= req_q.time_ns) begin
              margin = early_margin(diff_fwd);
              state_d[hs_idx] = ENT_MET;
              met_tot_d = met_tot_q + 64'd1;
            end else begin
              margin = late_margin(diff_rev);
              state_d[hs_idx] = ENT_MISSED;
              miss_tot_d = miss_tot_q + 64'd1;
            end
            if (act_tot_q != '0) act_tot_d = act_tot_q - 64'd1;
          end
        end
        KIND_CHECK: begin
          rsp_d.miss_count = '0;
        end
        KIND_QUERY: begin
          if (!hs_ok) begin
            rsp_d.status = STS_NOTFOUND;
            rsp_d.entry_state = ENT_CANCELLED;
          end else begin
            rsp_d.entry_state = rd_state;
          end
        end
        KIND_STAT: begin
          case (req_q.stat_select)
            SEL_REGISTERED: rsp_d.stat_value = reg_tot_q;
            SEL_ACTIVE:     rsp_d.stat_value = act_tot_q;
            SEL_MET:        rsp_d.stat_value = met_tot_q;
            SEL_MISSED:     rsp_d.stat_value = miss_tot_q;
            SEL_CANCELLED:  rsp_d.stat_value = canc_tot_q;
            SEL_WORST:      rsp_d.stat_value = worst_q;
            SEL_BEST:       rsp_d.stat_value = best_q;
            default:        rsp_d.stat_value = '0;
          endcase
        end
        default: begin
          rsp_d.status = STS_OK;
        end
      endcase
    end

    if (ctl_i.scan) begin
      idx_d = idx_q + CW'(1);
      if (act) begin
        case (req_q.kind)
          KIND_SHUTDOWN: begin
            if (rd_state == ENT_PENDING) begin
              state_d[rd_idx] = ENT_CANCELLED;
              canc_tot_d = canc_tot_q + 64'd1;
              if (act_tot_q != '0) act_tot_d = act_tot_q - 64'd1;
            end
          end
          KIND_REGISTER: begin
            if (rd_state != ENT_PENDING) begin
              found_d = 1'b1;
              fidx_d = rd_idx;
            end
          end
          KIND_CHECK: begin
            if ((rd_state == ENT_PENDING) && (req_q.time_ns >= rd_target)) begin
              state_d[rd_idx] = ENT_MISSED;
              miss_tot_d = miss_tot_q + 64'd1;
              if (act_tot_q != '0) act_tot_d = act_tot_q - 64'd1;
              if (misses_q != 5'd31) misses_d = misses_q + 5'd1;
              note = 1'b1;
              margin = late_margin(diff_rev);
              if (notify_q[rd_idx] && (rep_q < 5'(MaxReports))) begin
                rep_d = rep_q + 5'd1;
                rsp_valid_d = 1'b1;
                rsp_d.slot_index = 4'(rd_idx);
                rsp_d.miss_entity = entity_q[rd_idx];
                rsp_d.overdue_ns = diff_rev;
                rsp_d.is_miss_report = 1'b1;
                rsp_d.last = 1'b0;
              end
            end
          end
          default: begin
            found_d = found_q;
          end
        endcase
      end
    end

    if (ctl_i.finish) begin
      rsp_valid_d = 1'b1;
      case (req_q.kind)
        KIND_SHUTDOWN: begin
          running_d = 1'b0;
        end
        KIND_REGISTER: begin
          if (found_q) begin
            do_alloc = 1'b1;
          end else if (in_use_q >= CW'(SLOTS)) begin
            rsp_d.status = STS_FULL;
          end else begin
            do_alloc = 1'b1;
            alloc = in_use_q[IW-1:0];
            in_use_d = in_use_q + CW'(1);
          end
          if (do_alloc) begin
            gen_d[alloc] = bump_gen(gen_q[alloc]);
            target_d[alloc] = req_q.time_ns;
            entity_d[alloc] = req_q.owner_id;
            notify_d[alloc] = req_q.miss_notify;
            state_d[alloc] = ENT_PENDING;
            reg_tot_d = reg_tot_q + 64'd1;
            act_tot_d = act_tot_q + 64'd1;
            rsp_d.slot_index = 4'(alloc);
            rsp_d.generation = bump_gen(gen_q[alloc]);
          end
        end
        KIND_CHECK: begin
          rsp_d.miss_count = misses_q;
        end
        default: begin
          rsp_d.status = STS_OK;
        end
      endcase
    end

    if (note) begin
      if ((met_tot_q == '0) && (miss_tot_q == '0)) begin
        worst_d = margin;
        best_d = margin;
      end else begin
        if ($signed(margin) < $signed(worst_q)) worst_d = margin;
        if ($signed(best_q) < $signed(margin)) best_d = margin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        gen_q[i] <= '0;
        state_q[i] <= ENT_CANCELLED;
      end
      in_use_q <= '0;
      running_q <= 1'b0;
      reg_tot_q <= '0;
      act_tot_q <= '0;
      met_tot_q <= '0;
      miss_tot_q <= '0;
      canc_tot_q <= '0;
      worst_q <= '0;
      best_q <= '0;
      idx_q <= '0;
      found_q <= 1'b0;
      rep_q <= '0;
      misses_q <= '0;
      rsp_valid_o <= 1'b0;
    end else begin
      gen_q <= gen_d;
      state_q <= state_d;
      in_use_q <= in_use_d;
      running_q <= running_d;
      reg_tot_q <= reg_tot_d;
      act_tot_q <= act_tot_d;
      met_tot_q <= met_tot_d;
      miss_tot_q <= miss_tot_d;
      canc_tot_q <= canc_tot_d;
      worst_q <= worst_d;
      best_q <= best_d;
      idx_q <= idx_d;
      found_q <= found_d;
      rep_q <= rep_d;
      misses_q <= misses_d;
      rsp_valid_o <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q <= target_d;
    entity_q <= entity_d;
    notify_q <= notify_d;
    req_q <= req_d;
    fidx_q <= fidx_d;
    rsp_o <= rsp_d;
  end

endmodule

// ===== rtl/deadline_slot_monitor_core.sv =====
// A request without a walk (or register and check while stopped) has its result registered
// onto the ports from the execute state. Shutdown and check walk the slots in use and
// register walks up to its first free slot, one slot per cycle; the final result is then
// registered from the finish state. Miss reports leave during the walk.
// One request at a time: the next one is accepted at the edge that ends the result
// cycle; the receiver cannot stall. Reset clears slot states, generations and counters.
`timescale 1ns / 1ps
module deadline_slot_monitor_core #(
  parameter int unsigned SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  dsm_pkg::dsm_req_t req_i,
  output logic              busy_o,
  output logic              result_valid_o,
  output dsm_pkg::dsm_rsp_t rsp_o
);
  import dsm_pkg::*;

  dsm_ctl_t ctl;
  dsm_sts_t sts;

  dsm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .ctl_o   (ctl),
    .busy_o  (busy_o)
  );

  dsm_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .rsp_valid_o (result_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== bench/deadline_slot_monitor_core_tb.sv =====
`timescale 1ns / 1ps
module deadline_slot_monitor_core_tb;
  import dsm_pkg::*;

  localparam int NSLOT = 16;
  localparam int WATCHDOG = 20000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start_i = 1'b0;
  dsm_req_t req_i = '0;
  logic     busy_o;
  logic     result_valid_o;
  dsm_rsp_t rsp_o;

  deadline_slot_monitor_core #(.SLOTS(NSLOT)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
    .busy_o(busy_o), .result_valid_o(result_valid_o), .rsp_o(rsp_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [63:0] m_target [NSLOT];
  logic [63:0] m_entity [NSLOT];
  logic        m_notify [NSLOT];
  logic [15:0] m_gen    [NSLOT];
  entry_e      m_state  [NSLOT];
  int          m_used;
  bit          m_running;
  logic [63:0] n_reg, n_active, n_met, n_missed, n_cancel;
  logic signed [63:0] worst_m, best_m;

  dsm_rsp_t pending_rsp[$];
  int errors = 0;
  int accepted = 0;
  int results_seen = 0;
  int miss_reports = 0;
  int idle_cnt = 0;
  int gap_pct = 6;

  function automatic logic [15:0] gen_step(logic [15:0] g);
    logic [15:0] n;
    n = g + 16'd1;
    return (n == 16'd0) ? 16'd1 : n;
  endfunction

  function automatic bit valid_handle(logic [3:0] s, logic [15:0] g);
    return int'(s) < m_used && m_gen[s] == g;
  endfunction

  function automatic void record_margin(logic signed [63:0] m);
    if (n_met + n_missed == 64'd1) begin
      worst_m = m;
      best_m = m;
    end else begin
      if (m < worst_m) worst_m = m;
      if (m > best_m) best_m = m;
    end
  endfunction

  function automatic void drop_active();
    if (n_active > 0) n_active--;
  endfunction

  function automatic logic signed [63:0] late_of(logic [63:0] over);
    return over[63] ? 64'sh8000_0000_0000_0000 : -$signed(over);
  endfunction

  function automatic void reset_monitor();
    for (int i = 0; i < NSLOT; i++) begin
      m_target[i] = '0; m_entity[i] = '0; m_notify[i] = 1'b0; m_gen[i] = '0;
      m_state[i] = ENT_CANCELLED;
    end
    m_used = 0; m_running = 0;
    n_reg = 0; n_active = 0; n_met = 0; n_missed = 0; n_cancel = 0;
    worst_m = 0; best_m = 0;
  endfunction

  function automatic void predict_request(dsm_req_t q);
    dsm_rsp_t r;
    int idx;
    int reports;
    logic [4:0] misses;
    logic [63:0] over;
    r = '0;
    r.last = 1'b1;
    case (kind_e'(q.kind))
      KIND_INIT: begin
        for (int i = 0; i < NSLOT; i++) begin
          m_gen[i] = gen_step(m_gen[i]); m_state[i] = ENT_CANCELLED;
          m_target[i] = '0; m_entity[i] = '0; m_notify[i] = 1'b0;
        end
        m_used = 0;
        n_reg = 0; n_active = 0; n_met = 0; n_missed = 0; n_cancel = 0;
        worst_m = 0; best_m = 0;
        m_running = 1;
      end
      KIND_SHUTDOWN: begin
        for (int i = 0; i < m_used; i++)
          if (m_state[i] == ENT_PENDING) begin
            m_state[i] = ENT_CANCELLED; n_cancel++; drop_active();
          end
        m_running = 0;
      end
      KIND_REGISTER: begin
        idx = -1;
        if (!m_running) r.status = STS_INVALID;
        else begin
          for (int i = 0; i < m_used; i++)
            if (idx < 0 && m_state[i] != ENT_PENDING) idx = i;
          if (idx < 0 && m_used < NSLOT) begin
            idx = m_used; m_used++;
          end
          if (idx < 0) r.status = STS_FULL;
          else begin
            m_gen[idx] = gen_step(m_gen[idx]);
            m_target[idx] = q.time_ns; m_entity[idx] = q.owner_id;
            m_notify[idx] = q.miss_notify; m_state[idx] = ENT_PENDING;
            n_reg++; n_active++;
            r.slot_index = 4'(idx); r.generation = m_gen[idx];
          end
        end
      end
      KIND_CANCEL: begin
        if (!valid_handle(q.handle_slot, q.handle_generation)) r.status = STS_NOTFOUND;
        else if (m_state[q.handle_slot] == ENT_PENDING) begin
          m_state[q.handle_slot] = ENT_CANCELLED; n_cancel++; drop_active();
        end
      end
      KIND_COMPLETE: begin
        if (!valid_handle(q.handle_slot, q.handle_generation)) r.status = STS_NOTFOUND;
        else if (m_state[q.handle_slot] != ENT_PENDING) r.status = STS_INVALID;
        else if (m_target[q.handle_slot] >= q.time_ns) begin
          over = m_target[q.handle_slot] - q.time_ns;
          m_state[q.handle_slot] = ENT_MET; n_met++; drop_active();
          record_margin(over[63] ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(over));
        end else begin
          over = q.time_ns - m_target[q.handle_slot];
          m_state[q.handle_slot] = ENT_MISSED; n_missed++; drop_active();
          record_margin(late_of(over));
        end
      end
      KIND_CHECK: begin
        reports = 0;
        misses = 0;
        if (m_running)
          for (int i = 0; i < m_used; i++)
            if (m_state[i] == ENT_PENDING && q.time_ns >= m_target[i]) begin
              dsm_rsp_t mr;
              m_state[i] = ENT_MISSED; n_missed++; drop_active();
              if (misses < 31) misses++;
              over = q.time_ns - m_target[i];
              record_margin(late_of(over));
              if (m_notify[i] && reports < MaxReports) begin
                mr = '0;
                mr.slot_index = 4'(i); mr.miss_entity = m_entity[i];
                mr.overdue_ns = over; mr.is_miss_report = 1'b1;
                pending_rsp.push_back(mr);
                reports++;
              end
            end
        r.miss_count = misses;
      end
      KIND_QUERY: begin
        if (!valid_handle(q.handle_slot, q.handle_generation)) begin
          r.status = STS_NOTFOUND; r.entry_state = ENT_CANCELLED;
        end else r.entry_state = m_state[q.handle_slot];
      end
      default: begin
        case (sel_e'(q.stat_select))
          SEL_REGISTERED: r.stat_value = n_reg;
          SEL_ACTIVE:     r.stat_value = n_active;
          SEL_MET:        r.stat_value = n_met;
          SEL_MISSED:     r.stat_value = n_missed;
          SEL_CANCELLED:  r.stat_value = n_cancel;
          SEL_WORST:      r.stat_value = worst_m;
          SEL_BEST:       r.stat_value = best_m;
          default:        r.stat_value = '0;
        endcase
      end
    endcase
    pending_rsp.push_back(r);
  endfunction

  // Results are compared against the predicted queue at the sampling edge.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      dsm_rsp_t e;
      results_seen++;
      if (rsp_o.is_miss_report) miss_reports++;
      if (pending_rsp.size() == 0) begin
        $error("unexpected result %p", rsp_o);
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, rsp_o.status); errors++;
        end
        if (rsp_o.slot_index !== e.slot_index) begin
          $error("slot_index exp %0d got %0d", e.slot_index, rsp_o.slot_index); errors++;
        end
        if (rsp_o.generation !== e.generation) begin
          $error("generation exp %0d got %0d", e.generation, rsp_o.generation); errors++;
        end
        if (rsp_o.entry_state !== e.entry_state) begin
          $error("entry_state exp %0d got %0d", e.entry_state, rsp_o.entry_state); errors++;
        end
        if (rsp_o.miss_entity !== e.miss_entity) begin
          $error("miss_entity exp %h got %h", e.miss_entity, rsp_o.miss_entity); errors++;
        end
        if (rsp_o.overdue_ns !== e.overdue_ns) begin
          $error("overdue_ns exp %h got %h", e.overdue_ns, rsp_o.overdue_ns); errors++;
        end
        if (rsp_o.stat_value !== e.stat_value) begin
          $error("stat_value exp %0d got %0d", e.stat_value, rsp_o.stat_value); errors++;
        end
        if (rsp_o.miss_count !== e.miss_count) begin
          $error("miss_count exp %0d got %0d", e.miss_count, rsp_o.miss_count); errors++;
        end
        if (rsp_o.is_miss_report !== e.is_miss_report) begin
          $error("is_miss_report exp %0d got %0d", e.is_miss_report, rsp_o.is_miss_report);
          errors++;
        end
        if (rsp_o.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, rsp_o.last); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG) begin
      $display("watchdog expired with %0d results outstanding", pending_rsp.size());
      $display("FAILURE");
      $finish;
    end
  end

  // One request is held on start_i until accepted; the prediction runs at acceptance.
  // start_i stays high into the next request unless the sender idles first.
  task automatic issue(dsm_req_t q);
    if ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < gap_pct) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= q;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_request(q);
    accepted++;
  endtask

  function automatic dsm_req_t make_req(kind_e k, logic [63:0] t, logic [63:0] ent,
                                        logic nt, logic [3:0] hs, logic [15:0] hg,
                                        logic [2:0] sel);
    dsm_req_t q;
    q.kind = k; q.time_ns = t; q.owner_id = ent; q.miss_notify = nt;
    q.handle_slot = hs; q.handle_generation = hg; q.stat_select = sel;
    return q;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly valid handles from the live table, otherwise random ones.
  function automatic dsm_req_t random_req(logic [63:0] now);
    dsm_req_t q;
    int s;
    int pick;
    q = make_req(KIND_STAT, 64'd0, rand64(), 1'($urandom_range(1)),
                 4'($urandom_range(15)), 16'($urandom()), 3'($urandom_range(7)));
    pick = $urandom_range(99);
    s = (m_used > 0) ? $urandom_range(m_used - 1) : 0;
    if (pick < 32) begin
      q.kind = KIND_REGISTER;
      case ($urandom_range(5))
        0: q.time_ns = rand64();
        1: q.time_ns = {1'($urandom_range(1)), 61'd0, 2'($urandom_range(3))};
        default: q.time_ns = now + $urandom_range(400);
      endcase
    end else if (pick < 75) begin
      q.kind = (pick < 42) ? KIND_CANCEL : (pick < 60) ? KIND_COMPLETE : KIND_QUERY;
      if ($urandom_range(9) < 8) begin
        q.handle_slot = 4'(s); q.handle_generation = m_gen[s];
      end
      q.time_ns = ($urandom_range(9) == 0) ? rand64() : now + $urandom_range(400);
    end else if (pick < 88) begin
      q.kind = KIND_CHECK;
      q.time_ns = ($urandom_range(9) == 0) ? rand64() : now + $urandom_range(300);
    end else if (pick < 97) q.kind = KIND_STAT;
    else if (pick < 99) q.kind = KIND_SHUTDOWN;
    else q.kind = KIND_INIT;
    return q;
  endfunction

  typedef struct {
    dsm_req_t req;
    bit       typed;
    dsm_rsp_t rsp;
  } step_t;

  step_t steps[$];
  step_t st;
  dsm_rsp_t lit;
  logic [63:0] now;
  logic [63:0] all1;

  initial begin
    reset_monitor();
    all1 = '1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    lit = '0; lit.last = 1'b1;
    st.typed = 1;
    st.req = make_req(KIND_REGISTER, 5, 7, 1, 0, 0, 0);
    st.rsp = lit; st.rsp.status = STS_INVALID; steps.push_back(st);
    st.req = make_req(KIND_QUERY, 0, 0, 0, 0, 0, 0);
    st.rsp = lit; st.rsp.status = STS_NOTFOUND; st.rsp.entry_state = ENT_CANCELLED;
    steps.push_back(st);
    st.req = make_req(KIND_CHECK, all1, 0, 0, 0, 0, 0);
    st.rsp = lit; steps.push_back(st);
    st.req = make_req(KIND_INIT, 0, 0, 0, 0, 0, 0);
    st.rsp = lit; steps.push_back(st);
    st.req = make_req(KIND_STAT, 0, 0, 0, 0, 0, SEL_NONE);
    st.rsp = lit; steps.push_back(st);
    st.typed = 0;
    steps.push_back('{make_req(KIND_REGISTER, all1, all1, 1, 0, 0, 0), 0, lit});
    steps.push_back('{make_req(KIND_REGISTER, 0, 64'h1234, 1, 0, 0, 0), 0, lit});
    steps.push_back('{make_req(KIND_REGISTER, 100, 64'h55, 0, 0, 0, 0), 0, lit});
    steps.push_back('{make_req(KIND_REGISTER, 64'h8000_0000_0000_0000, 9, 1, 0, 0, 0), 0,
                      lit});
    steps.push_back('{make_req(KIND_COMPLETE, 0, 0, 0, 0, 16'd1, 0), 0, lit});
    steps.push_back('{make_req(KIND_COMPLETE, all1, 0, 0, 1, 16'd1, 0), 0, lit});
    steps.push_back('{make_req(KIND_COMPLETE, 5, 0, 0, 1, 16'd1, 0), 0, lit});
    steps.push_back('{make_req(KIND_CHECK, 100, 0, 0, 0, 0, 0), 0, lit});
    steps.push_back('{make_req(KIND_CANCEL, 0, 0, 0, 3, 16'hFFFF, 0), 0, lit});
    steps.push_back('{make_req(KIND_CANCEL, 0, 0, 0, 2, 16'd1, 0), 0, lit});
    steps.push_back('{make_req(KIND_QUERY, 0, 0, 0, 15, 16'd1, 0), 0, lit});
    steps.push_back('{make_req(KIND_CHECK, all1, 0, 0, 0, 0, 0), 0, lit});
    for (int s = 0; s < 7; s++)
      steps.push_back('{make_req(KIND_STAT, 0, 0, 0, 0, 0, 3'(s)), 0, lit});
    steps.push_back('{make_req(KIND_SHUTDOWN, 0, 0, 0, 0, 0, 0), 0, lit});
    steps.push_back('{make_req(KIND_INIT, 0, 0, 0, 0, 0, 0), 0, lit});

    foreach (steps[i]) begin
      if (steps[i].typed) begin
        issue(steps[i].req);
        void'(pending_rsp.pop_back());
        pending_rsp.push_back(steps[i].rsp);
      end else issue(steps[i].req);
    end

    now = 1000;
    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 6 : (phase == 1) ? 81 : 0;
      for (int n = 0; n < 55; n++) begin
        now = now + $urandom_range(40);
        issue(random_req(now));
      end
      // In the last phase, fill the table completely, then sweep it with a notifying check.
      if (phase == 2) begin
        for (int n = 0; n < 18; n++)
          issue(make_req(KIND_REGISTER, now + n, rand64(), 1, 0, 0, 0));
        issue(make_req(KIND_CHECK, all1, 0, 0, 0, 0, 0));
      end
    end
    start_i <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Covered %0d requests, %0d results, %0d miss reports.",
             accepted, results_seen, miss_reports);
    if (errors == 0 && pending_rsp.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dsm_pkg.sv
rtl/dsm_ctrl.sv
rtl/dsm_datapath.sv
rtl/deadline_slot_monitor_core.sv
bench/deadline_slot_monitor_core_tb.sv
